// ----- src/fmma_pkg.sv -----
`default_nettype none
package fmma_pkg;

    localparam int MAX_ROWS  = 64;
    localparam int MAX_COLS  = 64;
    localparam int MAX_DEPTH = 64;

    localparam int KIND_W    = 2;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;
    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int EXP_W     = 12;

    // Input item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD_A  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_B  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH = 3'd4;

    // Queued command codes
    typedef logic [1:0] op_t;
    localparam op_t OP_LOAD_A  = 2'd0;
    localparam op_t OP_LOAD_B  = 2'd1;
    localparam op_t OP_COMPUTE = 2'd2;

    localparam logic [DATA_W-1:0] QNAN32    = 32'h7FC0_0000;
    localparam logic [DATA_W-1:0] INF32     = 32'h7F80_0000;
    localparam logic [DATA_W-1:0] NEG_ZERO  = 32'h8000_0000;
    localparam logic [DATA_W-1:0] ALPHA_RST = 32'h3F80_0000;

    typedef struct packed {
        op_t                op;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [DATA_W-1:0]  value;
    } cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0]  alpha_bits;
        logic [DATA_W-1:0]  beta_bits;
        logic [CNT_W-1:0]   row_count;
        logic [CNT_W-1:0]   column_count;
        logic [CNT_W-1:0]   inner_depth;
    } cfg_t;

    // Position of the highest set bit, zero for an empty word
    function automatic logic [5:0] top_bit64(input logic [63:0] v);
        logic [5:0] n;
        n = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
            begin
                n = 6'(i);
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

// ----- src/fmma_item_if.sv -----
`default_nettype none
interface fmma_item_if;
    logic                         valid;
    logic                         ready;
    logic [fmma_pkg::KIND_W-1:0]  kind;
    logic [fmma_pkg::IDX_W-1:0]   row_index;
    logic [fmma_pkg::IDX_W-1:0]   col_index;
    logic [fmma_pkg::DATA_W-1:0]  elem_value;

    modport source (output valid, kind, row_index, col_index, elem_value, input ready);
    modport sink   (input valid, kind, row_index, col_index, elem_value, output ready);
endinterface
`default_nettype wire

// ----- src/fmma_result_if.sv -----
`default_nettype none
interface fmma_result_if;
    logic                         valid;
    logic                         ready;
    logic [fmma_pkg::IDX_W-1:0]   out_row;
    logic [fmma_pkg::IDX_W-1:0]   out_col;
    logic [fmma_pkg::DATA_W-1:0]  out_value;

    modport source (output valid, out_row, out_col, out_value, input ready);
    modport sink   (input valid, out_row, out_col, out_value, output ready);
endinterface
`default_nettype wire

// ----- src/fmma_cfg_if.sv -----
`default_nettype none
interface fmma_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [fmma_pkg::CFG_IDX_W-1:0]  index;
    logic [fmma_pkg::DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- src/fmma_front.sv -----
`default_nettype none
module fmma_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    fmma_item_if.sink            item,
    fmma_cfg_if.sink             cfg,
    input  wire logic            queue_full,
    output logic                 push,
    output fmma_pkg::cmd_t       push_cmd,
    output fmma_pkg::cfg_t       cfg_out
);

    fmma_pkg::cfg_t cfg_reg;
    fmma_pkg::cfg_t cfg_next;
    logic           keep;

    // Take register writes at any time
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                fmma_pkg::CFG_ALPHA: cfg_next.alpha_bits   = cfg.data;
                fmma_pkg::CFG_BETA:  cfg_next.beta_bits    = cfg.data;
                fmma_pkg::CFG_ROWS:  cfg_next.row_count    = cfg.data[fmma_pkg::CNT_W-1:0];
                fmma_pkg::CFG_COLS:  cfg_next.column_count = cfg.data[fmma_pkg::CNT_W-1:0];
                fmma_pkg::CFG_DEPTH: cfg_next.inner_depth  = cfg.data[fmma_pkg::CNT_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha_bits   <= fmma_pkg::ALPHA_RST;
            cfg_reg.beta_bits    <= '0;
            cfg_reg.row_count    <= fmma_pkg::CNT_W'(fmma_pkg::MAX_ROWS);
            cfg_reg.column_count <= fmma_pkg::CNT_W'(fmma_pkg::MAX_COLS);
            cfg_reg.inner_depth  <= fmma_pkg::CNT_W'(fmma_pkg::MAX_DEPTH);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_out = cfg_reg;

    // Classify the request: loads always go on, computes only inside the matrix, other kinds are dropped
    always_comb
    begin
        keep           = 1'b0;
        push_cmd.op    = fmma_pkg::OP_COMPUTE;
        push_cmd.row   = item.row_index;
        push_cmd.col   = item.col_index;
        push_cmd.value = item.elem_value;
        unique case (item.kind)
            fmma_pkg::KIND_LOAD_A:
            begin
                keep        = 1'b1;
                push_cmd.op = fmma_pkg::OP_LOAD_A;
            end
            fmma_pkg::KIND_LOAD_B:
            begin
                keep        = 1'b1;
                push_cmd.op = fmma_pkg::OP_LOAD_B;
            end
            fmma_pkg::KIND_COMPUTE:
            begin
                keep = ({1'b0, item.row_index} < cfg_reg.row_count) &&
                       ({1'b0, item.col_index} < cfg_reg.column_count);
            end
            default: keep = 1'b0;
        endcase
    end

    assign item.ready = !queue_full;
    assign push       = item.valid && !queue_full && keep;

endmodule
`default_nettype wire

// ----- src/fmma_queue.sv -----
`default_nettype none
module fmma_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  fmma_pkg::cmd_t       push_cmd,
    output logic                 full,
    output logic                 not_empty,
    input  wire logic            pop,
    output fmma_pkg::cmd_t       pop_cmd
);

    fmma_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold payload without reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

// ----- src/fmma_fma.sv -----
`default_nettype none
module fmma_fma (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [31:0]  op_a,
    input  wire logic [31:0]  op_b,
    input  wire logic [31:0]  op_c,
    output logic              done,
    output logic [31:0]       result
);

    localparam int EW = fmma_pkg::EXP_W;

    logic [7:1] v_reg;

    // Stage 1: unpack, special operands, mantissa product
    logic        sa, sb, sc, ps;
    logic [7:0]  ea, eb, ec, ea1, eb1, ec1;
    logic [22:0] fa, fb, fc;
    logic        az, bz, cz, nan_in;
    logic [23:0] ma, mb, mc;
    logic        spec1;
    logic [31:0] spec_val1;

    logic              s1_spec, s1_ps, s1_sc, s1_cz;
    logic [31:0]       s1_spec_val;
    logic [47:0]       s1_mp;
    logic [23:0]       s1_mc;
    logic signed [EW-1:0] s1_xp, s1_xc;

    always_comb
    begin
        sa  = op_a[31];
        sb  = op_b[31];
        sc  = op_c[31];
        ps  = sa ^ sb;
        ea  = op_a[30:23];
        eb  = op_b[30:23];
        ec  = op_c[30:23];
        fa  = op_a[22:0];
        fb  = op_b[22:0];
        fc  = op_c[22:0];
        az  = (op_a[30:0] == 31'd0);
        bz  = (op_b[30:0] == 31'd0);
        cz  = (op_c[30:0] == 31'd0);
        ea1 = (ea != 8'd0) ? ea : 8'd1;
        eb1 = (eb != 8'd0) ? eb : 8'd1;
        ec1 = (ec != 8'd0) ? ec : 8'd1;
        ma  = {ea != 8'd0, fa};
        mb  = {eb != 8'd0, fb};
        mc  = cz ? 24'd0 : {ec != 8'd0, fc};
        nan_in = (ea == 8'hFF && fa != 23'd0) || (eb == 8'hFF && fb != 23'd0) ||
                 (ec == 8'hFF && fc != 23'd0);
        spec1     = 1'b1;
        spec_val1 = op_c;
        if (nan_in)
        begin
            spec_val1 = fmma_pkg::QNAN32;
        end
        else if (ea == 8'hFF || eb == 8'hFF)
        begin
            if (az || bz || (ec == 8'hFF && sc != ps))
            begin
                spec_val1 = fmma_pkg::QNAN32;
            end
            else
            begin
                spec_val1 = {ps, fmma_pkg::INF32[30:0]};
            end
        end
        else if (ec == 8'hFF)
        begin
            spec_val1 = op_c;
        end
        else if (az || bz)
        begin
            spec_val1 = cz ? {ps & sc, 31'd0} : op_c;
        end
        else
        begin
            spec1 = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_spec     <= spec1;
        s1_spec_val <= spec_val1;
        s1_ps       <= ps;
        s1_sc       <= sc;
        s1_cz       <= cz;
        s1_mp       <= ma * mb;
        s1_mc       <= mc;
        s1_xp       <= $signed(EW'(ea1) + EW'(eb1) - EW'(300));
        s1_xc       <= $signed(EW'(ec1) - EW'(150));
    end

    // Stage 2: normalize both terms to bit 61
    logic [5:0]  shp, shc;
    logic [63:0] s2_mp, s2_mc;
    logic signed [EW-1:0] s2_xp, s2_xc;
    logic        s2_spec, s2_ps, s2_sc, s2_cz;
    logic [31:0] s2_spec_val;

    always_comb
    begin
        shp = 6'd61 - fmma_pkg::top_bit64({16'd0, s1_mp});
        shc = 6'd61 - fmma_pkg::top_bit64({40'd0, s1_mc});
    end

    always_ff @(posedge clk)
    begin
        s2_mp       <= {16'd0, s1_mp} << shp;
        s2_mc       <= {40'd0, s1_mc} << shc;
        s2_xp       <= s1_xp - $signed(EW'(shp));
        s2_xc       <= s1_xc - $signed(EW'(shc));
        s2_spec     <= s1_spec;
        s2_spec_val <= s1_spec_val;
        s2_ps       <= s1_ps;
        s2_sc       <= s1_sc;
        s2_cz       <= s1_cz;
    end

    // Stage 3: order by exponent, align the smaller term with sticky
    logic [63:0] big3, small3, small_al, lost_mask;
    logic signed [EW-1:0] ebig3, d3;
    logic        sbig3, ssmall3;

    logic [63:0] s3_big, s3_small;
    logic signed [EW-1:0] s3_e;
    logic        s3_sbig, s3_ssmall, s3_spec;
    logic [31:0] s3_spec_val;

    always_comb
    begin
        if (s2_cz)
        begin
            big3    = s2_mp;
            small3  = '0;
            ebig3   = s2_xp;
            d3      = '0;
            sbig3   = s2_ps;
            ssmall3 = s2_ps;
        end
        else if (s2_xp >= s2_xc)
        begin
            big3    = s2_mp;
            small3  = s2_mc;
            ebig3   = s2_xp;
            d3      = s2_xp - s2_xc;
            sbig3   = s2_ps;
            ssmall3 = s2_sc;
        end
        else
        begin
            big3    = s2_mc;
            small3  = s2_mp;
            ebig3   = s2_xc;
            d3      = s2_xc - s2_xp;
            sbig3   = s2_sc;
            ssmall3 = s2_ps;
        end
        lost_mask = (64'd1 << d3[5:0]) - 64'd1;
        if (d3 >= $signed(EW'(63)))
        begin
            small_al = 64'd1;
        end
        else
        begin
            small_al = (small3 >> d3[5:0]) | 64'((small3 & lost_mask) != 64'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        s3_big      <= big3;
        s3_small    <= small_al;
        s3_e        <= ebig3;
        s3_sbig     <= sbig3;
        s3_ssmall   <= ssmall3;
        s3_spec     <= s2_spec;
        s3_spec_val <= s2_spec_val;
    end

    // Stage 4: add or subtract magnitudes
    logic [63:0] r4;
    logic        sign4;

    logic [63:0] s4_r;
    logic signed [EW-1:0] s4_e;
    logic        s4_sign, s4_spec;
    logic [31:0] s4_spec_val;

    always_comb
    begin
        sign4 = s3_sbig;
        if (s3_sbig == s3_ssmall)
        begin
            r4 = s3_big + s3_small;
        end
        else if (s3_big >= s3_small)
        begin
            r4 = s3_big - s3_small;
        end
        else
        begin
            r4    = s3_small - s3_big;
            sign4 = s3_ssmall;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_r        <= r4;
        s4_e        <= s3_e;
        s4_sign     <= sign4;
        s4_spec     <= s3_spec;
        s4_spec_val <= s3_spec_val;
    end

    // Stage 5: find the leading one of the sum
    logic [63:0] s5_r;
    logic [5:0]  s5_p;
    logic signed [EW-1:0] s5_e;
    logic        s5_sign, s5_zero, s5_spec;
    logic [31:0] s5_spec_val;

    always_ff @(posedge clk)
    begin
        s5_r        <= s4_r;
        s5_p        <= fmma_pkg::top_bit64(s4_r);
        s5_e        <= s4_e;
        s5_sign     <= s4_sign;
        s5_zero     <= (s4_r == 64'd0);
        s5_spec     <= s4_spec;
        s5_spec_val <= s4_spec_val;
    end

    // Stage 6: pick the rounding point, with the subnormal floor
    logic signed [EW-1:0] sh6, lim6, neg_sh6, ex6;
    logic [63:0] up6, down6, rem6, half6, mask6;
    logic [23:0] q6;
    logic        inc6;

    logic [23:0] s6_q;
    logic        s6_inc, s6_sign, s6_zero, s6_spec;
    logic signed [EW-1:0] s6_ex;
    logic [31:0] s6_spec_val;

    always_comb
    begin
        sh6  = $signed(EW'(s5_p)) - $signed(EW'(23));
        lim6 = $signed(-EW'(149)) - s5_e;
        if (sh6 < lim6)
        begin
            sh6 = lim6;
        end
        neg_sh6 = -sh6;
        up6     = s5_r << neg_sh6[5:0];
        down6   = s5_r >> sh6[5:0];
        mask6   = (64'd1 << sh6[5:0]) - 64'd1;
        half6   = 64'd1 << (sh6[5:0] - 6'd1);
        rem6    = s5_r & mask6;
        if (sh6 <= $signed(EW'(0)))
        begin
            q6   = up6[23:0];
            inc6 = 1'b0;
        end
        else if (sh6 >= $signed(EW'(64)))
        begin
            q6   = '0;
            inc6 = 1'b0;
        end
        else
        begin
            q6   = down6[23:0];
            inc6 = (rem6 > half6) || (rem6 == half6 && down6[0]);
        end
        ex6 = sh6 + s5_e + $signed(EW'(149));
    end

    always_ff @(posedge clk)
    begin
        s6_q        <= q6;
        s6_inc      <= inc6;
        s6_ex       <= ex6;
        s6_sign     <= s5_sign;
        s6_zero     <= s5_zero;
        s6_spec     <= s5_spec;
        s6_spec_val <= s5_spec_val;
    end

    // Stage 7: round, pack, saturate to infinity
    logic [32:0] bits7;
    logic [31:0] res7;

    always_comb
    begin
        bits7 = {s6_ex[9:0], 23'd0} + 33'(s6_q) + 33'(s6_inc);
        if (s6_spec)
        begin
            res7 = s6_spec_val;
        end
        else if (s6_zero)
        begin
            res7 = '0;
        end
        else if (s6_ex >= $signed(EW'(255)) || bits7 >= 33'(fmma_pkg::INF32))
        begin
            res7 = {s6_sign, fmma_pkg::INF32[30:0]};
        end
        else
        begin
            res7 = {s6_sign, bits7[30:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        result <= res7;
    end

    // Advance the valid marks with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[6:1], start};
        end
    end

    assign done = v_reg[7];

endmodule
`default_nettype wire

// ----- src/fmma_back.sv -----
`default_nettype none
module fmma_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  fmma_pkg::cfg_t       cfg,
    input  wire logic            cmd_valid,
    input  fmma_pkg::cmd_t       cmd,
    output logic                 pop,
    fmma_result_if.source        result
);

    localparam int A_DEPTH  = fmma_pkg::MAX_ROWS * fmma_pkg::MAX_DEPTH;
    localparam int B_DEPTH  = fmma_pkg::MAX_DEPTH * fmma_pkg::MAX_COLS;
    localparam int A_ADDR_W = $clog2(A_DEPTH);
    localparam int B_ADDR_W = $clog2(B_DEPTH);

    localparam logic [3:0] ST_IDLE       = 4'd0;
    localparam logic [3:0] ST_READ       = 4'd1;
    localparam logic [3:0] ST_MAC        = 4'd2;
    localparam logic [3:0] ST_MAC_WAIT   = 4'd3;
    localparam logic [3:0] ST_SCALE      = 4'd4;
    localparam logic [3:0] ST_SCALE_WAIT = 4'd5;
    localparam logic [3:0] ST_FINAL      = 4'd6;
    localparam logic [3:0] ST_FINAL_WAIT = 4'd7;
    localparam logic [3:0] ST_HOLD       = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic [fmma_pkg::CNT_W-1:0] k_reg, k_next;
    logic [fmma_pkg::CNT_W-1:0] depth_sat;
    logic [fmma_pkg::IDX_W-1:0] row_reg, col_reg;
    logic [31:0] old_reg, acc_reg, acc_next, scaled_reg, scaled_next, res_reg, res_next;
    logic        out_valid_reg, out_valid_next;
    logic [fmma_pkg::IDX_W-1:0] out_row_reg, out_col_reg;
    logic [31:0] out_value_reg;
    logic        load_out;
    logic        beta_zero;

    logic [31:0] a_mem [A_DEPTH];
    logic [31:0] b_mem [B_DEPTH];
    logic [31:0] a_rd, b_rd;
    logic [A_ADDR_W-1:0] a_raddr;
    logic [B_ADDR_W-1:0] b_raddr;
    logic        a_we, b_we;

    logic        fma_start, fma_done;
    logic [31:0] fma_a, fma_b, fma_c, fma_res;

    assign depth_sat = (cfg.inner_depth > fmma_pkg::CNT_W'(fmma_pkg::MAX_DEPTH)) ?
                       fmma_pkg::CNT_W'(fmma_pkg::MAX_DEPTH) : cfg.inner_depth;
    assign beta_zero = (cfg.beta_bits[30:0] == 31'd0);

    // Stores: one write port, one registered read port each
    assign a_we    = pop && (cmd.op == fmma_pkg::OP_LOAD_A);
    assign b_we    = pop && (cmd.op == fmma_pkg::OP_LOAD_B);
    assign a_raddr = {row_reg, k_reg[fmma_pkg::IDX_W-1:0]};
    assign b_raddr = {k_reg[fmma_pkg::IDX_W-1:0], col_reg};

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            a_mem[{cmd.row, cmd.col}] <= cmd.value;
        end
        a_rd <= a_mem[a_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            b_mem[{cmd.row, cmd.col}] <= cmd.value;
        end
        b_rd <= b_mem[b_raddr];
    end

    // Shared fused multiply-add unit
    fmma_fma u_fma (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (fma_start),
        .op_a   (fma_a),
        .op_b   (fma_b),
        .op_c   (fma_c),
        .done   (fma_done),
        .result (fma_res)
    );

    always_comb
    begin
        fma_start = 1'b0;
        fma_a     = a_rd;
        fma_b     = b_rd;
        fma_c     = acc_reg;
        case (state_reg)
            ST_MAC:
            begin
                fma_start = 1'b1;
            end
            ST_SCALE:
            begin
                fma_start = !beta_zero;
                fma_a     = cfg.beta_bits;
                fma_b     = old_reg;
                fma_c     = fmma_pkg::NEG_ZERO;
            end
            ST_FINAL:
            begin
                fma_start = 1'b1;
                fma_a     = acc_reg;
                fma_b     = cfg.alpha_bits;
                fma_c     = scaled_reg;
            end
            default: fma_start = 1'b0;
        endcase
    end

    // Sequencer: loads are written as they are popped in idle, a compute walks the inner index
    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        acc_next    = acc_reg;
        scaled_next = scaled_reg;
        res_next    = res_reg;
        pop         = 1'b0;
        load_out    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    pop = 1'b1;
                    if (cmd.op == fmma_pkg::OP_COMPUTE)
                    begin
                        k_next     = '0;
                        acc_next   = '0;
                        state_next = (depth_sat == '0) ? ST_SCALE : ST_READ;
                    end
                end
            end
            ST_READ:       state_next = ST_MAC;
            ST_MAC:        state_next = ST_MAC_WAIT;
            ST_MAC_WAIT:
            begin
                if (fma_done)
                begin
                    acc_next   = fma_res;
                    k_next     = k_reg + 1'b1;
                    state_next = (k_reg + 1'b1 == depth_sat) ? ST_SCALE : ST_READ;
                end
            end
            ST_SCALE:
            begin
                if (beta_zero)
                begin
                    scaled_next = '0;
                    state_next  = ST_FINAL;
                end
                else
                begin
                    state_next = ST_SCALE_WAIT;
                end
            end
            ST_SCALE_WAIT:
            begin
                if (fma_done)
                begin
                    scaled_next = fma_res;
                    state_next  = ST_FINAL;
                end
            end
            ST_FINAL:      state_next = ST_FINAL_WAIT;
            ST_FINAL_WAIT:
            begin
                if (fma_done)
                begin
                    res_next   = fma_res;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold operands and the output register
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        scaled_reg <= scaled_next;
        res_reg    <= res_next;
        if (pop && cmd.op == fmma_pkg::OP_COMPUTE)
        begin
            row_reg <= cmd.row;
            col_reg <= cmd.col;
            old_reg <= cmd.value;
        end
        if (load_out)
        begin
            out_row_reg   <= row_reg;
            out_col_reg   <= col_reg;
            out_value_reg <= res_reg;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.out_row   = out_row_reg;
    assign result.out_col   = out_col_reg;
    assign result.out_value = out_value_reg;

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        fma_done |-> (state_reg == ST_MAC_WAIT || state_reg == ST_SCALE_WAIT ||
                      state_reg == ST_FINAL_WAIT))
        else $error("multiply-add result arrived outside a wait state");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == ST_IDLE && cmd_valid))
        else $error("queue popped while busy or empty");

    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (k_reg < depth_sat))
        else $error("inner index ran past the depth");

endmodule
`default_nettype wire

// ----- src/float_matrix_multiply_accumulate.sv -----
`default_nettype none
// Loads of A or B are written when the back end pops them from the two-entry queue.
// A compute request walks the inner index: each inner step is a store read, an issue
// and a pass through the fused multiply-add, then come the beta and alpha steps;
// the beta multiply is skipped when beta is zero. The back end takes no new command
// until the result of the current compute has moved to the output register.
// Reset clears control state and loads the register defaults; the A and B stores
// are undefined until written and get no clearing pass.
module float_matrix_multiply_accumulate (
    input  wire logic      clk,
    input  wire logic      rst_n,
    fmma_item_if.sink      item,
    fmma_result_if.source  result,
    fmma_cfg_if.sink       cfg
);

    logic           push, pop, queue_full, queue_valid;
    fmma_pkg::cmd_t push_cmd, pop_cmd;
    fmma_pkg::cfg_t cfg_val;

    fmma_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .cfg        (cfg),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd),
        .cfg_out    (cfg_val)
    );

    fmma_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .not_empty (queue_valid),
        .pop       (pop),
        .pop_cmd   (pop_cmd)
    );

    fmma_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_val),
        .cmd_valid (queue_valid),
        .cmd       (pop_cmd),
        .pop       (pop),
        .result    (result)
    );

endmodule
`default_nettype wire
